FILE: rtl/klpg_pkg.sv
// Shared types and constants for the Korobov lattice point generator.
package klpg_pkg;

    localparam int DATA_W    = 16;
    localparam int DIM_W     = 4;
    localparam int DIMS_W    = 5;
    localparam int COUNT_W   = 17;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = 32;
    // modular reduction retires two dividend bits per cycle
    localparam int MR_STEPS  = PROD_W / 2;
    localparam int MR_CNT_W  = $clog2(MR_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_LATTICE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLIER   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSIONS   = 2'd3;

    localparam logic MODE_PRIME = 1'b0;
    localparam logic MODE_POW2  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CH_MUL,
        ST_CH_WAIT,
        ST_ZERO,
        ST_EXH,
        ST_PT_RD,
        ST_PT_USE,
        ST_PT_MOD,
        ST_PT_OUT,
        ST_HEAD_INC
    } klpg_state_t;

endpackage

FILE: rtl/klpg_ram.sv
// Simple dual-port synchronous RAM, one write port, one registered read port.
module klpg_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/klpg_modred.sv
// Sequential remainder unit: 32-bit dividend mod 16-bit divisor, two bits per cycle.
module klpg_modred (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [klpg_pkg::PROD_W-1:0]   dividend,
    input  logic [klpg_pkg::DATA_W-1:0]   divisor,
    output logic                          busy,
    output logic                          done,
    output logic [klpg_pkg::DATA_W-1:0]   rem
);

    logic [klpg_pkg::PROD_W-1:0]   dvd_reg, dvd_next;
    logic [klpg_pkg::DATA_W-1:0]   rem_reg, rem_next;
    logic [klpg_pkg::DATA_W-1:0]   div_reg, div_next;
    logic [klpg_pkg::MR_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;

    logic [klpg_pkg::DATA_W:0]     r1, r2;
    logic [klpg_pkg::DATA_W-1:0]   r1s, r2s;

    always_comb
    begin
        r1  = {rem_reg, dvd_reg[klpg_pkg::PROD_W-1]};
        r1s = (r1 >= {1'b0, div_reg}) ? klpg_pkg::DATA_W'(r1 - {1'b0, div_reg})
                                      : r1[klpg_pkg::DATA_W-1:0];
        r2  = {r1s, dvd_reg[klpg_pkg::PROD_W-2]};
        r2s = (r2 >= {1'b0, div_reg}) ? klpg_pkg::DATA_W'(r2 - {1'b0, div_reg})
                                      : r2[klpg_pkg::DATA_W-1:0];

        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[klpg_pkg::PROD_W-3:0], 2'b00};
            rem_next = r2s;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == klpg_pkg::MR_CNT_W'(klpg_pkg::MR_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rem  = rem_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("modred started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("modred done without a running reduction");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && div_reg != '0) |-> rem_reg < div_reg)
        else $error("modred remainder not below divisor");

    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> $past(start))
        else $error("modred went busy without start");

endmodule

FILE: rtl/korobov_lattice_point_generator.sv
// Top level of the Korobov rank-1 lattice point generator.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------------
//  cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//  in       | in_valid / in_ready     | restart
//  out      | out_valid / out_ready   | coord_numerator, dim_index, last_coord, exhausted
//
// One item at a time; in_ready is high only while the sequencer is idle.
// Restart: rebuilds the chain, one modular multiply (multiply, reduction, write) per entry.
// Request: the first point is all zeros; prime mode rebuilds the chain after each point;
//   power-of-two mode reduces a dimension only when its sum passes n; exhausted is one
//   item. Memory reads are registered.
// Reset clears control, configuration, the point count and accumulator valid bits.
// A stalled out_ready holds the sequencer in its emitting state; cfg_ready is always high.
module korobov_lattice_point_generator #(
    parameter int MAX_DIM = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [klpg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [klpg_pkg::DATA_W-1:0]      cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             restart,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [klpg_pkg::DATA_W-1:0]      coord_numerator,
    output logic [klpg_pkg::DIM_W-1:0]       dim_index,
    output logic                             last_coord,
    output logic                             exhausted
);

    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW = $clog2(MAX_DIM + 1);

    // configuration
    logic                            mode_reg;
    logic [klpg_pkg::DATA_W-1:0]     modulus_reg;
    logic [klpg_pkg::DATA_W-1:0]     mult_reg;
    logic [klpg_pkg::DIMS_W-1:0]     dims_reg;

    // sequencer
    klpg_pkg::klpg_state_t           state_reg, state_next;
    logic [CW-1:0]                   idx_reg, idx_next;
    logic [klpg_pkg::DATA_W-1:0]     prev_reg, prev_next;
    logic [klpg_pkg::DATA_W-1:0]     head_reg, head_next;
    logic [klpg_pkg::DATA_W-1:0]     val_reg, val_next;
    logic [klpg_pkg::COUNT_W-1:0]    pd_reg, pd_next;
    logic [MAX_DIM-1:0]              vld_reg, vld_next;

    // output register
    logic                            out_valid_reg;
    logic [klpg_pkg::DATA_W-1:0]     coord_reg;
    logic [klpg_pkg::DIM_W-1:0]      dim_reg;
    logic                            last_reg;
    logic                            exh_reg;

    logic                            load;
    logic [klpg_pkg::DATA_W-1:0]     ld_coord;
    logic [klpg_pkg::DIM_W-1:0]      ld_dim;
    logic                            ld_last;
    logic                            ld_exh;

    // memories
    logic                            ch_we;
    logic [AW-1:0]                   ch_waddr;
    logic [klpg_pkg::DATA_W-1:0]     ch_wdata;
    logic [klpg_pkg::DATA_W-1:0]     ch_rdata;
    logic                            acc_we;
    logic [klpg_pkg::DATA_W-1:0]     acc_rdata;

    // reduction unit
    logic                            mr_start;
    logic [klpg_pkg::PROD_W-1:0]     mr_dvd;
    logic                            mr_busy;
    logic                            mr_done;
    logic [klpg_pkg::DATA_W-1:0]     mr_rem;

    logic [klpg_pkg::DATA_W-1:0]     n_eff;
    logic [klpg_pkg::DIMS_W-1:0]     dims_cl;
    logic [CW-1:0]                   dims_eff;
    logic [AW-1:0]                   addr;
    logic                            is_last;
    logic                            idx_at_end;
    logic                            can_load;
    logic [klpg_pkg::DATA_W-1:0]     acc_cur;
    logic [klpg_pkg::DATA_W:0]       sum17;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= klpg_pkg::MODE_PRIME;
            modulus_reg <= klpg_pkg::DATA_W'(2);
            mult_reg    <= klpg_pkg::DATA_W'(1);
            dims_reg    <= klpg_pkg::DIMS_W'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                klpg_pkg::CFG_LATTICE_MODE: mode_reg    <= cfg_data[0];
                klpg_pkg::CFG_MODULUS:      modulus_reg <= cfg_data;
                klpg_pkg::CFG_MULTIPLIER:   mult_reg    <= cfg_data;
                klpg_pkg::CFG_DIMENSIONS:   dims_reg    <= cfg_data[klpg_pkg::DIMS_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        n_eff      = (modulus_reg == '0) ? klpg_pkg::DATA_W'(1) : modulus_reg;
        dims_cl    = (dims_reg == '0) ? klpg_pkg::DIMS_W'(1) : dims_reg;
        dims_eff   = (int'(dims_cl) > MAX_DIM) ? CW'(MAX_DIM) : CW'(dims_cl);
        addr       = idx_reg[AW-1:0];
        is_last    = (({1'b0, idx_reg} + (CW+1)'(1)) == {1'b0, dims_eff});
        idx_at_end = (idx_reg == CW'(MAX_DIM));
        can_load   = !out_valid_reg || out_ready;
        // an accumulator not written since restart reads as zero
        acc_cur    = vld_reg[addr] ? acc_rdata : '0;
        sum17      = {1'b0, acc_cur} + {1'b0, ch_rdata};
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        prev_next  = prev_reg;
        head_next  = head_reg;
        val_next   = val_reg;
        pd_next    = pd_reg;
        vld_next   = vld_reg;
        in_ready   = 1'b0;
        ch_we      = 1'b0;
        ch_waddr   = addr;
        ch_wdata   = mr_rem;
        acc_we     = 1'b0;
        mr_start   = 1'b0;
        mr_dvd     = klpg_pkg::PROD_W'(prev_reg) * klpg_pkg::PROD_W'(mult_reg);
        load       = 1'b0;
        ld_coord   = val_reg;
        ld_dim     = klpg_pkg::DIM_W'(idx_reg);
        ld_last    = is_last;
        ld_exh     = 1'b0;

        unique case (state_reg)
            klpg_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (restart)
                    begin
                        pd_next    = '0;
                        vld_next   = '0;
                        ch_we      = 1'b1;
                        ch_waddr   = '0;
                        ch_wdata   = klpg_pkg::DATA_W'(1);
                        prev_next  = klpg_pkg::DATA_W'(1);
                        idx_next   = CW'(1);
                        state_next = klpg_pkg::ST_CH_MUL;
                    end
                    else
                    begin
                        idx_next = '0;
                        priority if (pd_reg == '0)
                            state_next = klpg_pkg::ST_ZERO;
                        else if (pd_reg > {1'b0, n_eff})
                            state_next = klpg_pkg::ST_EXH;
                        else
                            state_next = klpg_pkg::ST_PT_RD;
                    end
                end
            end

            klpg_pkg::ST_CH_MUL:
            begin
                if (idx_at_end)
                begin
                    state_next = klpg_pkg::ST_IDLE;
                end
                else
                begin
                    mr_start   = 1'b1;
                    state_next = klpg_pkg::ST_CH_WAIT;
                end
            end

            klpg_pkg::ST_CH_WAIT:
            begin
                if (mr_done)
                begin
                    ch_we      = 1'b1;
                    prev_next  = mr_rem;
                    idx_next   = idx_reg + 1'b1;
                    state_next = klpg_pkg::ST_CH_MUL;
                end
            end

            klpg_pkg::ST_ZERO:
            begin
                ld_coord = '0;
                if (can_load)
                begin
                    load = 1'b1;
                    if (is_last)
                    begin
                        pd_next    = klpg_pkg::COUNT_W'(1);
                        state_next = klpg_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            klpg_pkg::ST_EXH:
            begin
                ld_coord = '0;
                ld_dim   = '0;
                ld_last  = 1'b1;
                ld_exh   = 1'b1;
                if (can_load)
                begin
                    load       = 1'b1;
                    state_next = klpg_pkg::ST_IDLE;
                end
            end

            klpg_pkg::ST_PT_RD:
            begin
                state_next = klpg_pkg::ST_PT_USE;
            end

            klpg_pkg::ST_PT_USE:
            begin
                if (mode_reg == klpg_pkg::MODE_PRIME)
                begin
                    val_next = ch_rdata;
                    if (idx_reg == '0)
                    begin
                        head_next = ch_rdata;
                    end
                    state_next = klpg_pkg::ST_PT_OUT;
                end
                else if (sum17 > {1'b0, n_eff})
                begin
                    // wrap into 1..n: ((acc - 1) mod n) + 1
                    mr_start   = 1'b1;
                    mr_dvd     = klpg_pkg::PROD_W'(sum17 - (klpg_pkg::DATA_W+1)'(1));
                    state_next = klpg_pkg::ST_PT_MOD;
                end
                else
                begin
                    val_next   = sum17[klpg_pkg::DATA_W-1:0];
                    state_next = klpg_pkg::ST_PT_OUT;
                end
            end

            klpg_pkg::ST_PT_MOD:
            begin
                if (mr_done)
                begin
                    val_next   = mr_rem + klpg_pkg::DATA_W'(1);
                    state_next = klpg_pkg::ST_PT_OUT;
                end
            end

            klpg_pkg::ST_PT_OUT:
            begin
                if (can_load)
                begin
                    load           = 1'b1;
                    acc_we         = 1'b1;
                    vld_next[addr] = 1'b1;
                    if (is_last)
                    begin
                        pd_next = pd_reg + klpg_pkg::COUNT_W'(1);
                        if (mode_reg == klpg_pkg::MODE_PRIME)
                            state_next = klpg_pkg::ST_HEAD_INC;
                        else
                            state_next = klpg_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = klpg_pkg::ST_PT_RD;
                    end
                end
            end

            klpg_pkg::ST_HEAD_INC:
            begin
                ch_we      = 1'b1;
                ch_waddr   = '0;
                ch_wdata   = head_reg + klpg_pkg::DATA_W'(1);
                prev_next  = head_reg + klpg_pkg::DATA_W'(1);
                idx_next   = CW'(1);
                state_next = klpg_pkg::ST_CH_MUL;
            end

            default:
            begin
                state_next = klpg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= klpg_pkg::ST_IDLE;
            idx_reg       <= '0;
            pd_reg        <= '0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pd_reg    <= pd_next;
            vld_reg   <= vld_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
        head_reg <= head_next;
        val_reg  <= val_next;
        if (load)
        begin
            coord_reg <= ld_coord;
            dim_reg   <= ld_dim;
            last_reg  <= ld_last;
            exh_reg   <= ld_exh;
        end
    end

    assign out_valid       = out_valid_reg;
    assign coord_numerator = coord_reg;
    assign dim_index       = dim_reg;
    assign last_coord      = last_reg;
    assign exhausted       = exh_reg;

    klpg_ram #(
        .DEPTH (MAX_DIM),
        .WIDTH (klpg_pkg::DATA_W)
    ) u_chain_ram (
        .clk   (clk),
        .we    (ch_we),
        .waddr (ch_waddr),
        .wdata (ch_wdata),
        .raddr (addr),
        .rdata (ch_rdata)
    );

    klpg_ram #(
        .DEPTH (MAX_DIM),
        .WIDTH (klpg_pkg::DATA_W)
    ) u_accum_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (addr),
        .wdata (val_reg),
        .raddr (addr),
        .rdata (acc_rdata)
    );

    klpg_modred u_modred (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mr_start),
        .dividend (mr_dvd),
        .divisor  (n_eff),
        .busy     (mr_busy),
        .done     (mr_done),
        .rem      (mr_rem)
    );

    a_exh_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && exh_reg) |-> (last_reg && coord_reg == '0 && dim_reg == '0))
        else $error("exhausted item malformed");

    a_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !mr_busy)
        else $error("accepting an item while reduction runs");

    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        mr_done |-> (state_reg == klpg_pkg::ST_CH_WAIT || state_reg == klpg_pkg::ST_PT_MOD))
        else $error("reduction result arrived in wrong state");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == klpg_pkg::ST_PT_OUT && can_load && is_last)
        |=> pd_reg == $past(pd_reg) + klpg_pkg::COUNT_W'(1))
        else $error("point count not advanced after a point");

endmodule
